/* hw/rtl/spi_pkg.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Shared widths, the CORDIC arctangent table and the gain constant.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int CoordW       = 18;
  localparam int LenW         = 16;
  localparam int AngW         = 16;
  localparam int TolW         = 32;
  localparam int AtanEntries  = 24;
  localparam int CordicStagesDef = 16;
  localparam int GainQ16      = 39797;
  // CORDIC vector: length (16 bit) times gain (16 bit) plus growth and sign.
  localparam int VecW         = 36;
  localparam int ZW           = 33;

  localparam logic [31:0] AtanTab [AtanEntries] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // End point coordinates grow past the start point by up to one length.
  localparam int PtW = 20;

  typedef struct packed {
    logic signed [PtW-1:0] ax;
    logic signed [PtW-1:0] ay;
    logic signed [PtW-1:0] bx;
    logic signed [PtW-1:0] by;
  } seg_pts_t;

endpackage

/* hw/rtl/spi_cordic.sv */
// ----------------------------------------------------------------------------
// CORDIC end point unit
// Pipelined rotation of the gain-compensated length, one stage per register.
// ----------------------------------------------------------------------------
module spi_cordic import spi_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [LenW-1:0]          len_i,
  input  logic [AngW-1:0]          ang_i,
  output logic signed [PtW-1:0]    dx_o,
  output logic signed [PtW-1:0]    dy_o
);

  localparam int NSt = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

  logic signed [VecW-1:0] x_q [NSt+1];
  logic signed [VecW-1:0] y_q [NSt+1];
  logic signed [ZW-1:0]   z_q [NSt+1];
  logic signed [VecW-1:0] x0_d;
  logic [31:0]            z0_d;
  logic signed [VecW-1:0] rx_d, ry_d;

  always_comb begin
    x0_d = $signed({1'b0, len_i}) * $signed(18'(GainQ16));
    z0_d = {ang_i, 16'h0000};
    if (ang_i >= 16'h4000 && ang_i < 16'hC000) begin
      x0_d = -x0_d;
      z0_d = z0_d - 32'h80000000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= '0;
      z_q[0] <= ZW'($signed(z0_d));
    end
  end

  for (genvar i = 0; i < NSt; i++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ZW'(AtanTab[i]);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ZW'(AtanTab[i]);
        end
      end
    end
  end

  always_comb begin
    rx_d = (x_q[NSt] + VecW'(32768)) >>> 16;
    ry_d = (y_q[NSt] + VecW'(32768)) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_o <= PtW'(rx_d);
      dy_o <= PtW'(ry_d);
    end
  end

endmodule

/* hw/rtl/spi_orient.sv */
// ----------------------------------------------------------------------------
// Orientation and decision unit
// Coordinate differences in one stage, cross products in the next, classes in
// the third and the decision in the last.
// ----------------------------------------------------------------------------
module spi_orient import spi_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TolW-1:0]   tol_i,
  input  seg_pts_t          p_i,
  input  seg_pts_t          q_i,
  output logic              hit_o,
  output logic              col_o
);

  localparam int DW = PtW + 1;
  localparam int MW = 2 * DW + 1;

  localparam logic [1:0] OrZero = 2'd0;
  localparam logic [1:0] OrPos  = 2'd1;
  localparam logic [1:0] OrNeg  = 2'd2;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] d;
  } diffs_t;

  diffs_t               d_q [4];
  logic signed [MW-1:0] v_q [4];
  seg_pts_t             p_q, q_q, p2_q, q2_q, p3_q, q3_q;
  logic [1:0]           o_q [4];

  function automatic diffs_t diffs(
    input logic signed [PtW-1:0] px, input logic signed [PtW-1:0] py,
    input logic signed [PtW-1:0] qx, input logic signed [PtW-1:0] qy,
    input logic signed [PtW-1:0] rx, input logic signed [PtW-1:0] ry);
    diffs_t r;
    r.a = DW'(qy) - DW'(py);
    r.b = DW'(rx) - DW'(qx);
    r.c = DW'(qx) - DW'(px);
    r.d = DW'(ry) - DW'(qy);
    return r;
  endfunction

  function automatic logic signed [MW-1:0] cross_val(input diffs_t dv);
    logic signed [2*DW-1:0] ab, cd;
    ab = dv.a * dv.b;
    cd = dv.c * dv.d;
    return MW'(ab) - MW'(cd);
  endfunction

  function automatic logic in_box(
    input logic signed [PtW-1:0] px, input logic signed [PtW-1:0] py,
    input logic signed [PtW-1:0] qx, input logic signed [PtW-1:0] qy,
    input logic signed [PtW-1:0] rx, input logic signed [PtW-1:0] ry);
    logic xa, ya;
    xa = (px < rx) ? (qx >= px && qx <= rx) : (qx >= rx && qx <= px);
    ya = (py < ry) ? (qy >= py && qy <= ry) : (qy >= ry && qy <= py);
    return xa && ya;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= diffs(p_i.ax, p_i.ay, q_i.ax, q_i.ay, p_i.bx, p_i.by);
      d_q[1] <= diffs(p_i.ax, p_i.ay, q_i.ax, q_i.ay, q_i.bx, q_i.by);
      d_q[2] <= diffs(p_i.bx, p_i.by, q_i.bx, q_i.by, p_i.ax, p_i.ay);
      d_q[3] <= diffs(p_i.bx, p_i.by, q_i.bx, q_i.by, q_i.ax, q_i.ay);
      p_q <= p_i;
      q_q <= q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) v_q[k] <= cross_val(d_q[k]);
      p2_q <= p_q;
      q2_q <= q_q;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_cls
    logic [MW-1:0] mag;
    assign mag = v_q[k][MW-1] ? MW'(-v_q[k]) : MW'(v_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (mag < MW'(tol_i)) o_q[k] <= OrZero;
        else if (v_q[k] > 0) o_q[k] <= OrPos;
        else o_q[k] <= OrNeg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q <= p2_q;
      q3_q <= q2_q;
    end
  end

  logic gen_d, colf_d;
  always_comb begin
    gen_d  = (o_q[0] != o_q[1]) && (o_q[2] != o_q[3]);
    colf_d =
      (o_q[0] == OrZero && in_box(p3_q.ax, p3_q.ay, p3_q.bx, p3_q.by, q3_q.ax, q3_q.ay)) ||
      (o_q[1] == OrZero && in_box(p3_q.ax, p3_q.ay, q3_q.bx, q3_q.by, q3_q.ax, q3_q.ay)) ||
      (o_q[2] == OrZero && in_box(p3_q.bx, p3_q.by, p3_q.ax, p3_q.ay, q3_q.bx, q3_q.by)) ||
      (o_q[3] == OrZero && in_box(p3_q.bx, p3_q.by, q3_q.ax, q3_q.ay, q3_q.bx, q3_q.by));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= gen_d || colf_d;
      col_o <= !gen_d && colf_d;
    end
  end

endmodule

/* hw/rtl/segment_pair_intersection_top.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection top level
// Input beats pass the CORDIC input, stage and output registers, then the orientation unit's registers.
// Throughput is one beat per cycle; a stall freezes the whole pipeline.
// Reset clears valid bits and sets zero_tolerance to 256; no clearing pass.
// ----------------------------------------------------------------------------
module segment_pair_intersection_top import spi_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_len, a_ang, b_x, b_y, b_len, b_ang from the lowest bit up.
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // intersects, collinear_touch from the lowest bit up.
  output logic [7:0]   m_axis_tdata
);

  localparam int NSt = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;
  localparam int Lat = NSt + 6;

  logic [TolW-1:0] tol_q;
  logic [Lat-1:0]  vld_q;
  logic            en;
  logic signed [CoordW-1:0] sx [4];
  seg_pts_t        p_sr_q [NSt+2];
  seg_pts_t        p_d, q_d;
  logic signed [PtW-1:0] dax, day, dbx, dby;
  logic            hit, col;

  assign en = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {6'b0, col, hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(256);
      vld_q <= '0;
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  assign sx[0] = s_axis_tdata[17:0];
  assign sx[1] = s_axis_tdata[35:18];
  assign sx[2] = s_axis_tdata[85:68];
  assign sx[3] = s_axis_tdata[103:86];

  always_comb begin
    p_d.ax = PtW'(sx[0]);
    p_d.ay = PtW'(sx[1]);
    p_d.bx = PtW'(sx[2]);
    p_d.by = PtW'(sx[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sr_q[0] <= p_d;
      for (int i = 0; i < NSt + 1; i++) p_sr_q[i+1] <= p_sr_q[i];
    end
  end

  spi_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_ca (
    .clk_i, .en_i(en), .len_i(s_axis_tdata[51:36]), .ang_i(s_axis_tdata[67:52]),
    .dx_o(dax), .dy_o(day));
  spi_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cb (
    .clk_i, .en_i(en), .len_i(s_axis_tdata[119:104]), .ang_i(s_axis_tdata[135:120]),
    .dx_o(dbx), .dy_o(dby));

  always_comb begin
    q_d.ax = p_sr_q[NSt+1].ax + dax;
    q_d.ay = p_sr_q[NSt+1].ay + day;
    q_d.bx = p_sr_q[NSt+1].bx + dbx;
    q_d.by = p_sr_q[NSt+1].by + dby;
  end

  spi_orient u_or (
    .clk_i, .en_i(en), .tol_i(tol_q), .p_i(p_sr_q[NSt+1]), .q_i(q_d),
    .hit_o(hit), .col_o(col));

endmodule
